// File: rtl/ici_pkg.sv
// ici_pkg: shared types, constants and calibration tables for the
// inverse calibration interpolator. No dependencies.
package ici_pkg;

   localparam int POINTS    = 11;
   localparam int SEGS      = POINTS - 1;
   localparam int FRAC_BITS = 8;
   localparam int TARGET_W  = 16;
   localparam int VOLT_W    = 12;
   localparam int REQ_DATA_W = ((TARGET_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((VOLT_W + 7) / 8) * 8;
   localparam int RPM_SCALE = 10000;
   localparam int VOLT_BASE = 2;
   localparam int ROM_W     = 18;
   localparam int T_W       = 30;
   localparam int PT_W      = $clog2(POINTS);
   localparam int SEG_W     = (SEGS > 1) ? $clog2(SEGS) : 1;
   localparam int N_W       = ROM_W + FRAC_BITS + 2;
   localparam int D_W       = ROM_W + 1;
   localparam int RECIP_S   = N_W;
   localparam int Q_W       = FRAC_BITS + 1;

   localparam logic [T_W-1:0] RPM_SCALE_T = T_W'(RPM_SCALE);

   typedef enum logic [1:0] {
      KIND_BELOW,
      KIND_ABOVE,
      KIND_INTERP,
      KIND_NONE
   } kind_type;

   typedef struct packed {
      logic [T_W-1:0]  t;
      logic [SEGS-1:0] hit;
      logic            below;
      logic            above;
   } cmp_type;

   typedef struct packed {
      logic [N_W-1:0]     num;
      logic [D_W-1:0]     den;
      logic [RECIP_S-1:0] recip;
      logic [VOLT_W-1:0]  base;
      kind_type           kind;
   } div_type;

   typedef struct packed {
      logic [Q_W-1:0]    q;
      logic [VOLT_W-1:0] base;
      kind_type          kind;
   } res_type;

   // speed entries in 1/10000 rpm, entry i belongs to VOLT_BASE + i volts
   function automatic logic [ROM_W-1:0] rpm_rom(input logic [PT_W-1:0] idx);
      logic [ROM_W-1:0] r;
      case (idx)
         0:       r = ROM_W'(27100);
         1:       r = ROM_W'(48125);
         2:       r = ROM_W'(70950);
         3:       r = ROM_W'(102725);
         4:       r = ROM_W'(128750);
         5:       r = ROM_W'(149250);
         6:       r = ROM_W'(177275);
         7:       r = ROM_W'(213075);
         8:       r = ROM_W'(235475);
         9:       r = ROM_W'(260750);
         10:      r = ROM_W'(260250);
         default: r = '0;
      endcase
      return r;
   endfunction

   // floor(2^RECIP_S / (2 * segment width))
   function automatic logic [RECIP_S-1:0] seg_recip(input logic [SEG_W-1:0] s);
      logic [RECIP_S-1:0] r;
      case (s)
         0:       r = RECIP_S'(6383);
         1:       r = RECIP_S'(5880);
         2:       r = RECIP_S'(4224);
         3:       r = RECIP_S'(5157);
         4:       r = RECIP_S'(6547);
         5:       r = RECIP_S'(4789);
         6:       r = RECIP_S'(3749);
         7:       r = RECIP_S'(5991);
         8:       r = RECIP_S'(5310);
         9:       r = RECIP_S'(268435);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [ROM_W-1:0] rom_max();
      logic [ROM_W-1:0] m;
      m = rpm_rom(PT_W'(0));
      for (int i = 1; i < POINTS; i++) begin
         if (rpm_rom(PT_W'(i)) > m) begin
            m = rpm_rom(PT_W'(i));
         end
      end
      return m;
   endfunction

   localparam logic [ROM_W-1:0] RMAX = rom_max();

   function automatic logic [T_W-1:0] scaled(input logic [ROM_W-1:0] x);
      return T_W'(x) << FRAC_BITS;
   endfunction

   function automatic logic [ROM_W-1:0] seg_r0(input logic [SEG_W-1:0] s);
      return rpm_rom(PT_W'(s));
   endfunction

   function automatic logic [ROM_W-1:0] seg_r1(input logic [SEG_W-1:0] s);
      return rpm_rom(PT_W'(s) + PT_W'(1));
   endfunction

   function automatic logic seg_rising(input logic [SEG_W-1:0] s);
      return seg_r1(s) >= seg_r0(s);
   endfunction

   function automatic logic [ROM_W-1:0] seg_lo(input logic [SEG_W-1:0] s);
      return seg_rising(s) ? seg_r0(s) : seg_r1(s);
   endfunction

   function automatic logic [ROM_W-1:0] seg_hi(input logic [SEG_W-1:0] s);
      return seg_rising(s) ? seg_r1(s) : seg_r0(s);
   endfunction

   function automatic logic [ROM_W-1:0] seg_w(input logic [SEG_W-1:0] s);
      return seg_hi(s) - seg_lo(s);
   endfunction

   // rising: 2*r0s - w, falling: 2*r0s + w, so that num = 2d + w in one add
   function automatic logic [T_W:0] seg_bias(input logic [SEG_W-1:0] s);
      logic [T_W:0] b;
      b = (T_W + 1)'(scaled(seg_r0(s))) << 1;
      if (seg_rising(s)) begin
         b = b - (T_W + 1)'(seg_w(s));
      end else begin
         b = b + (T_W + 1)'(seg_w(s));
      end
      return b;
   endfunction

   function automatic logic [VOLT_W-1:0] volt_of(input logic [PT_W-1:0] idx);
      return VOLT_W'((VOLT_BASE + int'(idx)) << FRAC_BITS);
   endfunction

   localparam logic [VOLT_W-1:0] VMIN = volt_of(PT_W'(0));
   localparam logic [VOLT_W-1:0] VMAX = volt_of(PT_W'(POINTS - 1));

endpackage

// File: rtl/inverse_calibration_interpolator.sv
// inverse_calibration_interpolator: top level, stream ports and output register.
// Depends on ici_pkg, ici_scale_cmp, ici_segment and ici_divide.
//
// Maps a target speed (unsigned, 8 fraction bits) to a drive voltage of 2 to 12 V
// (unsigned, 8 fraction bits) by inverse linear interpolation in a fixed 11-point
// calibration table, rounding to nearest. Speeds at or below the first entry give
// 2 V with in_range set; speeds at or above the table maximum give 12 V with
// in_range cleared. The block takes one transfer every cycle while the output is
// not back-pressured. One stage scales the speed, one compares it against every
// entry, two pick the segment and form the operands, three run the reciprocal
// multiply with its one-step correction, and the last registers the clamped
// result. Every stage fills while the output waits, so up to 8 items are in flight.
module inverse_calibration_interpolator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ici_pkg::REQ_DATA_W-1:0]  req_tdata,   // [15:0] target speed
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ici_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [11:0] voltage, rest zero
   output logic                            rsp_tuser    // [0] in_range
);
   import ici_pkg::*;

   logic              cmp_valid;
   logic              cmp_ready;
   cmp_type           cmp_data;
   logic              seg_valid;
   logic              seg_ready;
   div_type           seg_data;
   logic              res_valid;
   logic              res_ready;
   res_type           res_data;
   logic              rsp_valid_ff;
   logic [VOLT_W-1:0] rsp_volt_ff;
   logic [VOLT_W-1:0] rsp_volt_in;
   logic              rsp_ok_ff;
   logic              rsp_ok_in;
   logic [VOLT_W:0]   sum;

   ici_scale_cmp u_scale_cmp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_target (req_tdata[TARGET_W-1:0]),
      .out_valid (cmp_valid),
      .out_ready (cmp_ready),
      .out_data  (cmp_data)
   );

   ici_segment u_segment (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmp_valid),
      .in_ready  (cmp_ready),
      .in_data   (cmp_data),
      .out_valid (seg_valid),
      .out_ready (seg_ready),
      .out_data  (seg_data)
   );

   ici_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seg_valid),
      .in_ready  (seg_ready),
      .in_data   (seg_data),
      .out_valid (res_valid),
      .out_ready (res_ready),
      .out_data  (res_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;
   assign sum       = (VOLT_W + 1)'(res_data.base) + (VOLT_W + 1)'(res_data.q);

   always_comb begin
      case (res_data.kind)
         KIND_BELOW: begin
            rsp_volt_in = VMIN;
            rsp_ok_in   = 1'b1;
         end
         KIND_ABOVE: begin
            rsp_volt_in = VMAX;
            rsp_ok_in   = 1'b0;
         end
         KIND_INTERP: begin
            if (sum > (VOLT_W + 1)'(VMAX)) begin
               rsp_volt_in = VMAX;
            end else if (sum < (VOLT_W + 1)'(VMIN)) begin
               rsp_volt_in = VMIN;
            end else begin
               rsp_volt_in = sum[VOLT_W-1:0];
            end
            rsp_ok_in = 1'b1;
         end
         default: begin
            rsp_volt_in = VMAX;
            rsp_ok_in   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready) begin
         rsp_volt_ff <= rsp_volt_in;
         rsp_ok_ff   <= rsp_ok_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - VOLT_W)'(0), rsp_volt_ff};
   assign rsp_tuser  = rsp_ok_ff;

   a_volt_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_volt_ff >= VMIN) && (rsp_volt_ff <= VMAX))
      else $error("voltage outside 2..12 V");

   a_sat_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_volt_ff == VMAX)
      else $error("out of range result not at 12 V");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output back-pressure");

endmodule

// File: rtl/ici_scale_cmp.sv
// ici_scale_cmp: scales the target speed and compares it against all
// calibration entries in parallel. Depends on ici_pkg.
module ici_scale_cmp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [ici_pkg::TARGET_W-1:0]   in_target,
   output logic                           out_valid,
   input  logic                           out_ready,
   output ici_pkg::cmp_type               out_data
);
   import ici_pkg::*;

   logic           s1_valid_ff;
   logic [T_W-1:0] s1_t_ff;
   logic [T_W-1:0] s1_t_in;
   logic           s2_valid_ff;
   cmp_type        s2_data_ff;
   cmp_type        s2_data_in;
   logic           s1_ready;
   logic           s2_ready;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_t_in = T_W'(in_target) * RPM_SCALE_T;

   always_comb begin
      s2_data_in.t     = s1_t_ff;
      s2_data_in.below = s1_t_ff <= scaled(rpm_rom(PT_W'(0)));
      s2_data_in.above = s1_t_ff >= scaled(RMAX);
      for (int i = 0; i < SEGS; i++) begin
         s2_data_in.hit[i] = (seg_hi(SEG_W'(i)) > seg_lo(SEG_W'(i)))
                             && (s1_t_ff >= scaled(seg_lo(SEG_W'(i))))
                             && (s1_t_ff <= scaled(seg_hi(SEG_W'(i))));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_t_ff <= s1_t_in;
      end
      if (s2_ready) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// File: rtl/ici_segment.sv
// ici_segment: picks the first matching segment and forms the numerator,
// denominator, reciprocal and base voltage. Depends on ici_pkg.
module ici_segment (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ici_pkg::cmp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output ici_pkg::div_type out_data
);
   import ici_pkg::*;

   logic             b1_valid_ff;
   logic [SEG_W-1:0] b1_seg_ff;
   logic [SEG_W-1:0] b1_seg_in;
   kind_type         b1_kind_ff;
   kind_type         b1_kind_in;
   logic [T_W-1:0]   b1_t_ff;
   logic             found;
   logic             b2_valid_ff;
   div_type          b2_data_ff;
   div_type          b2_data_in;
   logic [T_W:0]     two_t;
   logic [T_W:0]     bias;
   logic [T_W:0]     num;
   logic             b1_ready;
   logic             b2_ready;

   assign b2_ready = !b2_valid_ff || out_ready;
   assign b1_ready = !b1_valid_ff || b2_ready;
   assign in_ready = b1_ready;

   // lowest matching segment wins
   always_comb begin
      b1_seg_in = '0;
      found     = 1'b0;
      for (int i = SEGS - 1; i >= 0; i--) begin
         if (in_data.hit[i]) begin
            b1_seg_in = SEG_W'(i);
            found     = 1'b1;
         end
      end
      if (in_data.below) begin
         b1_kind_in = KIND_BELOW;
      end else if (in_data.above) begin
         b1_kind_in = KIND_ABOVE;
      end else if (found) begin
         b1_kind_in = KIND_INTERP;
      end else begin
         b1_kind_in = KIND_NONE;
      end
   end

   assign two_t = {b1_t_ff, 1'b0};
   assign bias  = seg_bias(b1_seg_ff);
   assign num   = seg_rising(b1_seg_ff) ? (two_t - bias) : (bias - two_t);

   always_comb begin
      b2_data_in.num   = num[N_W-1:0];
      b2_data_in.den   = {seg_w(b1_seg_ff), 1'b0};
      b2_data_in.recip = seg_recip(b1_seg_ff);
      b2_data_in.base  = volt_of(PT_W'(b1_seg_ff));
      b2_data_in.kind  = b1_kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
      end else begin
         if (b1_ready) begin
            b1_valid_ff <= in_valid;
         end
         if (b2_ready) begin
            b2_valid_ff <= b1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b1_ready) begin
         b1_seg_ff  <= b1_seg_in;
         b1_kind_ff <= b1_kind_in;
         b1_t_ff    <= in_data.t;
      end
      if (b2_ready) begin
         b2_data_ff <= b2_data_in;
      end
   end

   assign out_valid = b2_valid_ff;
   assign out_data  = b2_data_ff;

endmodule

// File: rtl/ici_divide.sv
// ici_divide: rounded quotient by reciprocal multiply, back-multiply and
// one correction step over three stages. Depends on ici_pkg.
module ici_divide (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ici_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output ici_pkg::res_type out_data
);
   import ici_pkg::*;

   logic [N_W+RECIP_S-1:0] prod;
   logic                   c1_valid_ff;
   logic [Q_W-1:0]         c1_qa_ff;
   div_type                c1_data_ff;
   logic                   c2_valid_ff;
   logic [Q_W-1:0]         c2_qa_ff;
   logic [N_W-1:0]         c2_qd_ff;
   logic [N_W-1:0]         c2_qd_in;
   div_type                c2_data_ff;
   logic [N_W-1:0]         rem;
   logic                   c3_valid_ff;
   res_type                c3_data_ff;
   res_type                c3_data_in;
   logic                   c1_ready;
   logic                   c2_ready;
   logic                   c3_ready;

   assign c3_ready = !c3_valid_ff || out_ready;
   assign c2_ready = !c2_valid_ff || c3_ready;
   assign c1_ready = !c1_valid_ff || c2_ready;
   assign in_ready = c1_ready;

   assign prod     = (N_W + RECIP_S)'(in_data.num) * (N_W + RECIP_S)'(in_data.recip);
   assign c2_qd_in = N_W'(N_W'(c1_qa_ff) * N_W'(c1_data_ff.den));
   assign rem      = c2_data_ff.num - c2_qd_ff;

   // estimate is low by at most one
   always_comb begin
      c3_data_in.q    = c2_qa_ff + Q_W'(N_W'(rem) >= N_W'(c2_data_ff.den));
      c3_data_in.base = c2_data_ff.base;
      c3_data_in.kind = c2_data_ff.kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
         c3_valid_ff <= 1'b0;
      end else begin
         if (c1_ready) begin
            c1_valid_ff <= in_valid;
         end
         if (c2_ready) begin
            c2_valid_ff <= c1_valid_ff;
         end
         if (c3_ready) begin
            c3_valid_ff <= c2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c1_ready) begin
         c1_qa_ff   <= prod[RECIP_S +: Q_W];
         c1_data_ff <= in_data;
      end
      if (c2_ready) begin
         c2_qa_ff   <= c1_qa_ff;
         c2_qd_ff   <= c2_qd_in;
         c2_data_ff <= c1_data_ff;
      end
      if (c3_ready) begin
         c3_data_ff <= c3_data_in;
      end
   end

   assign out_valid = c3_valid_ff;
   assign out_data  = c3_data_ff;

   a_quot_estimate: assert property (@(posedge clock) disable iff (reset)
      c2_valid_ff && (c2_data_ff.kind == KIND_INTERP)
      |-> (c2_qd_ff <= c2_data_ff.num)
          && ((N_W + 1)'(rem) < (N_W + 1)'({c2_data_ff.den, 1'b0})))
      else $error("quotient estimate off by more than one");

endmodule
